// ----- rtl/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

  localparam int unsigned MaxPattern  = 16;
  localparam int unsigned OffsetBits  = 32;
  localparam int unsigned MatchOffW   = 32;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned PatFieldW   = 5;
  localparam int unsigned LenW        = $clog2(MaxPattern + 1);
  localparam int unsigned WinIdxW     = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatLow   = 2'd0,
    RegPatHigh  = 2'd1,
    RegWildMask = 2'd2,
    RegPatLen   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [MatchOffW-1:0] match_offset;
  } out_t;

  typedef logic [MaxPattern-1:0][7:0] window_t;

  typedef struct packed {
    window_t               pattern;
    logic [MaxPattern-1:0] wild;
    logic [LenW-1:0]       pat_len;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/wbps_cfg.sv -----
// Configuration register file: pattern bytes, wildcard mask, clamped pattern length.
`default_nettype none
module wbps_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [wbps_pkg::CfgIdxW-1:0]  idx_i,
  input  wire logic [wbps_pkg::CfgDataW-1:0] wdata_i,
  output wbps_pkg::cfg_t                     cfg_o
);
  import wbps_pkg::*;

  logic [63:0]         pat_low_q, pat_high_q;
  logic [15:0]         wild_q;
  logic [LenW-1:0]     len_q;
  logic [127:0]        pat_all;

  // zero reads as one, anything past the window depth as the full depth
  function automatic logic [LenW-1:0] clamp_len(input logic [PatFieldW-1:0] l);
    logic [LenW-1:0] r;
    if (l == '0) begin
      r = LenW'(1);
    end else if (32'(l) > MaxPattern) begin
      r = LenW'(MaxPattern);
    end else begin
      r = LenW'(l);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= LenW'(1);
    end else if (we_i) begin
      unique case (cfg_reg_e'(idx_i))
        RegPatLow:   pat_low_q  <= wdata_i[63:0];
        RegPatHigh:  pat_high_q <= wdata_i[63:0];
        RegWildMask: wild_q     <= wdata_i[15:0];
        RegPatLen:   len_q      <= clamp_len(wdata_i[PatFieldW-1:0]);
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      cfg_o.pattern[i] = pat_all[8*i +: 8];
      cfg_o.wild[i]    = wild_q[i];
    end
    cfg_o.pat_len = len_q;
  end

endmodule
`default_nettype wire

// ----- rtl/wbps_cmp.sv -----
// Parallel window compare: does the pattern end at the newest window byte.
`default_nettype none
module wbps_cmp (
  input  wire wbps_pkg::window_t window_i,
  input  wire wbps_pkg::cfg_t    cfg_i,
  output logic                   match_o
);
  import wbps_pkg::*;

  logic [MaxPattern-1:0] pos_ok;
  logic [LenW-1:0]       idx [MaxPattern];

  // pattern byte i lines up with window entry len-1-i (entry 0 is newest)
  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      idx[i] = cfg_i.pat_len - LenW'(i) - LenW'(1);
      if (LenW'(i) >= cfg_i.pat_len) begin
        pos_ok[i] = 1'b1;
      end else begin
        pos_ok[i] = cfg_i.wild[i] ||
                    (window_i[idx[i][WinIdxW-1:0]] == cfg_i.pattern[i]);
      end
    end
    match_o = &pos_ok;
  end

endmodule
`default_nettype wire

// ----- rtl/wildcard_byte_pattern_scanner_top.sv -----
// Top level: input register, window/count state, compare, output register.
// Path: a byte is held in the input register; any result it yields is registered in the output register.
// Throughput: one byte per cycle while the output side takes results.
// With both registers full, in_ready_o follows out_ready_i.
// Reset: window, byte count, match flag and both pipeline valid flags clear;
// configuration returns to pattern zero, no wildcards, pattern length one.
`default_nettype none
module wildcard_byte_pattern_scanner_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire wbps_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output wbps_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [wbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wbps_pkg::*;

  localparam logic [OffsetBits-1:0] SeenMax = '1;

  cfg_t                  cfg;
  logic                  st_valid_q;
  in_t                   st_data_q;
  window_t               window_q, window_d;
  logic [OffsetBits-1:0] seen_q, seen_d;
  logic                  reported_q;
  logic                  out_valid_q;
  out_t                  out_data_q;

  logic                  advance;
  logic                  cmp_match;
  logic                  hit, emit;
  logic [OffsetBits-1:0] offset_full;

  wbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  always_comb begin
    window_d[0] = st_data_q.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      window_d[k] = window_q[k-1];
    end
    seen_d = (seen_q == SeenMax) ? seen_q : seen_q + OffsetBits'(1);
  end

  wbps_cmp u_cmp (
    .window_i (window_d),
    .cfg_i    (cfg),
    .match_o  (cmp_match)
  );

  assign advance     = st_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !st_valid_q || advance;
  assign hit         = !reported_q && cmp_match && (seen_d >= OffsetBits'(cfg.pat_len));
  assign emit        = hit || (!reported_q && st_data_q.last_byte);
  assign offset_full = seen_d - OffsetBits'(cfg.pat_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      window_q    <= '0;
      seen_q      <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        st_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= emit;
        if (st_data_q.last_byte) begin
          window_q   <= '0;
          seen_q     <= '0;
          reported_q <= 1'b0;
        end else if (!reported_q) begin
          window_q   <= window_d;
          seen_q     <= seen_d;
          reported_q <= hit;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      st_data_q <= in_data_i;
    end
    if (advance && emit) begin
      out_data_q.found        <= hit;
      out_data_q.match_offset <= hit ? MatchOffW'(offset_full) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a not-found result always carries a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // the final byte of a dump leaves the count and match flag cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && st_data_q.last_byte |=> seen_q == '0 && !reported_q)
    else $error("dump state not cleared after final byte");

  // a reported match implies at least one byte counted in this dump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> seen_q != '0)
    else $error("match flag set with empty dump");

  // a stalled output never lets the staged transaction advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("stage advanced into stalled output");

endmodule
`default_nettype wire
